// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/ptq_pkg.sv =====
// Types and constants of the periodic timer event queue.
package ptq_pkg;

	localparam int WAIT_W = 51;
	localparam int SLOT_W = 4;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_CANCEL = 2'd2,
		REQ_ACCEPT = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_BUSY      = 2'd1,
		STS_FREE      = 2'd2,
		STS_TOO_LARGE = 2'd3
	} sts_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_ADD,
		OP_CANCEL,
		OP_ACCEPT,
		OP_REJECT
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_STEP
	} bk_state_t;

	typedef struct packed {
		op_t                op;
		logic [SLOT_W-1:0]  slot;
		sts_t               status;
		logic [WAIT_W-1:0]  wait_ticks;
		logic               periodic;
	} cmd_t;

	typedef struct packed {
		logic               kind;
		logic [SLOT_W-1:0]  slot_id;
		logic [1:0]         status;
		logic               last;
	} res_t;

endpackage

// ===== sv/ptq_req_if.sv =====
// Request channel of the timer event queue.
interface ptq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [3:0]  slot;
	logic [50:0] wait_ticks;
	logic        periodic;

	modport source (output valid, req_type, slot, wait_ticks, periodic, input ready);
	modport sink   (input valid, req_type, slot, wait_ticks, periodic, output ready);
endinterface

// ===== sv/ptq_res_if.sv =====
// Result channel of the timer event queue.
interface ptq_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [3:0] slot_id;
	logic [1:0] status;
	logic       last;

	modport source (output valid, kind, slot_id, status, last, input ready);
	modport sink   (input valid, kind, slot_id, status, last, output ready);
endinterface

// ===== sv/periodic_timer_event_queue_unit.sv =====
// Top level of the periodic timer event queue.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, slot, wait_ticks, periodic
//   res      out  valid/ready    kind, slot_id, status, last
//
// An add, cancel or accept item passes through the front queue and then the slot
// table and gives one result; it waits while the result register is full.
// A tick item snapshots the expiring slots, scans age ranks until none remain and
// advances the tick counter; a full result register stalls the scan.
// Meanwhile the two-entry queue keeps taking items until it is full.
// Reset clears all slot flags, ranks and the tick counter at once.
module periodic_timer_event_queue_unit import ptq_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int TICK_BITS = 50
) (
	input  logic      clk,
	input  logic      arst_n,
	ptq_req_if.sink   req,
	ptq_res_if.source res
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// Decode requests, reject bad slots and oversized waits early.
	ptq_front #(.NUM_SLOTS(NUM_SLOTS), .TICK_BITS(TICK_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Carry out commands against the slot table, scan expiries on a tick.
	ptq_back #(.NUM_SLOTS(NUM_SLOTS), .TICK_BITS(TICK_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res       (res)
	);

endmodule

// ===== sv/ptq_front.sv =====
// Request decode and two-entry command queue.
module ptq_front import ptq_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int TICK_BITS = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	ptq_req_if.sink     req,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	localparam int EXT_W = TICK_BITS + WAIT_W;

	cmd_t             mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	cmd_t             dec;
	logic [EXT_W-1:0] wext;
	logic             too_large;
	logic             slot_ok;
	logic             push;

	assign wext      = EXT_W'(req.wait_ticks);
	assign too_large = |wext[EXT_W-1:TICK_BITS];
	assign slot_ok   = 32'(req.slot) < NUM_SLOTS;

	always_comb begin
		dec.slot       = req.slot;
		dec.status     = STS_OK;
		dec.periodic   = req.periodic;
		dec.wait_ticks = (req.wait_ticks == '0) ? WAIT_W'(1) : req.wait_ticks;
		priority if (req_t'(req.req_type) == REQ_TICK) begin
			dec.op = OP_TICK;
		end else if (req_t'(req.req_type) == REQ_ADD && too_large) begin
			dec.op     = OP_REJECT;
			dec.status = STS_TOO_LARGE;
		end else if (!slot_ok) begin
			dec.op     = OP_REJECT;
			dec.status = STS_FREE;
		end else if (req_t'(req.req_type) == REQ_ADD) begin
			dec.op = OP_ADD;
		end else if (req_t'(req.req_type) == REQ_CANCEL) begin
			dec.op = OP_CANCEL;
		end else begin
			dec.op = OP_ACCEPT;
		end
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= dec;
	end

endmodule

// ===== sv/ptq_back.sv =====
// Slot table, expiry scan and result register.
module ptq_back import ptq_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int TICK_BITS = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	ptq_res_if.source   res
);

	localparam int RW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int EXT_W = TICK_BITS + WAIT_W;

	bk_state_t            state_q, state_d;
	logic [NUM_SLOTS-1:0] in_use_q, queued_q, sent_q, exp_q, rep_q;
	logic [RW-1:0]        rank_q [NUM_SLOTS];
	logic [RW-1:0]        snap_q [NUM_SLOTS];
	logic [TICK_BITS-1:0] deadline_q [NUM_SLOTS];
	logic [TICK_BITS-1:0] period_q [NUM_SLOTS];
	logic [TICK_BITS-1:0] tick_q;
	logic [RW-1:0]        r_q;
	logic                 out_valid_q;
	res_t                 out_q;

	logic [NUM_SLOTS-1:0] hit, sel;
	logic [RW-1:0]        rank_e, rank_s;
	logic [TICK_BITS-1:0] period_e, period_s, w;
	logic [EXT_W-1:0]     wext;
	logic [RW+SLOT_W-1:0] sext;
	logic [RW+SLOT_W-1:0] eext;
	logic [RW-1:0]        e;
	logic                 out_free, emit, do_snap, do_step, do_adv, do_cmd, r_inc;
	res_t                 emit_res;

	assign wext = EXT_W'(cmd.wait_ticks);
	assign w    = wext[TICK_BITS-1:0];
	assign sext = (RW+SLOT_W)'(cmd.slot);

	always_comb begin
		e        = '0;
		rank_e   = '0;
		rank_s   = '0;
		period_e = '0;
		period_s = '0;
		for (int j = 0; j < NUM_SLOTS; j++) begin
			hit[j] = exp_q[j] && (snap_q[j] == r_q);
			sel[j] = (sext[RW-1:0] == RW'(j));
			if (hit[j]) begin
				e        = e | RW'(j);
				rank_e   = rank_e | rank_q[j];
				period_e = period_e | period_q[j];
			end
			if (sel[j]) begin
				rank_s   = rank_s | rank_q[j];
				period_s = period_s | period_q[j];
			end
		end
	end

	assign eext     = (RW+SLOT_W)'(e);
	assign out_free = !out_valid_q || res.ready;

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		emit     = 1'b0;
		do_snap  = 1'b0;
		do_step  = 1'b0;
		do_adv   = 1'b0;
		do_cmd   = 1'b0;
		r_inc    = 1'b0;
		emit_res = '{kind: KIND_STATUS, slot_id: cmd.slot, status: STS_OK, last: 1'b1};
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_TICK) begin
						cmd_pop = 1'b1;
						do_snap = 1'b1;
						state_d = BK_STEP;
					end else if (out_free) begin
						cmd_pop = 1'b1;
						emit    = 1'b1;
						case (cmd.op)
							OP_REJECT: emit_res.status = cmd.status;
							OP_ADD: begin
								if (|(in_use_q & sel)) emit_res.status = STS_BUSY;
								else do_cmd = 1'b1;
							end
							default: begin
								if (|(in_use_q & sel)) do_cmd = 1'b1;
								else emit_res.status = STS_FREE;
							end
						endcase
					end
				end
			end
			BK_STEP: begin
				if (exp_q == '0) begin
					do_adv  = 1'b1;
					state_d = BK_IDLE;
				end else if (|hit) begin
					if (!(|(rep_q & hit)) || out_free) begin
						do_step = 1'b1;
						r_inc   = 1'b1;
						emit    = |(rep_q & hit);
						emit_res.kind    = KIND_EXPIRY;
						emit_res.slot_id = eext[SLOT_W-1:0];
						emit_res.last    = ((rep_q & ~hit) == '0);
					end
				end else begin
					r_inc = 1'b1;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control and table flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			in_use_q    <= '0;
			queued_q    <= '0;
			sent_q      <= '0;
			exp_q       <= '0;
			rep_q       <= '0;
			tick_q      <= '0;
			r_q         <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < NUM_SLOTS; j++) rank_q[j] <= '0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			if (r_inc) r_q <= r_q + RW'(1);
			if (do_adv) tick_q <= tick_q + TICK_BITS'(1);
			if (do_snap) begin
				r_q <= '0;
				for (int j = 0; j < NUM_SLOTS; j++) begin
					exp_q[j] <= queued_q[j] && (deadline_q[j] == tick_q);
					rep_q[j] <= queued_q[j] && (deadline_q[j] == tick_q) && !sent_q[j];
				end
			end
			if (do_step) begin
				exp_q  <= exp_q & ~hit;
				rep_q  <= rep_q & ~hit;
				sent_q <= sent_q | hit;
				for (int j = 0; j < NUM_SLOTS; j++) begin
					if (hit[j]) begin
						rank_q[j] <= '0;
						if (period_e == '0) queued_q[j] <= 1'b0;
					end else if (queued_q[j]) begin
						if (period_e != '0 && rank_q[j] < rank_e)
							rank_q[j] <= rank_q[j] + RW'(1);
						else if (period_e == '0 && rank_q[j] > rank_e)
							rank_q[j] <= rank_q[j] - RW'(1);
					end
				end
			end
			if (do_cmd) begin
				for (int j = 0; j < NUM_SLOTS; j++) begin
					if (cmd.op == OP_ADD) begin
						if (sel[j]) begin
							in_use_q[j] <= 1'b1;
							sent_q[j]   <= 1'b0;
							queued_q[j] <= 1'b1;
							rank_q[j]   <= '0;
						end else if (queued_q[j]) begin
							rank_q[j] <= rank_q[j] + RW'(1);
						end
					end else if (cmd.op == OP_ACCEPT && period_s != '0) begin
						if (sel[j]) sent_q[j] <= 1'b0;
					end else begin
						// Free the slot and close the gap in the age order.
						if (sel[j]) begin
							in_use_q[j] <= 1'b0;
							sent_q[j]   <= 1'b0;
							queued_q[j] <= 1'b0;
							rank_q[j]   <= '0;
						end else if (queued_q[j] && (|(queued_q & sel)) && rank_q[j] > rank_s) begin
							rank_q[j] <= rank_q[j] - RW'(1);
						end
					end
				end
			end
		end
	end

	// Payload: deadlines, periods, rank snapshot, result register.
	always_ff @(posedge clk) begin
		if (emit) out_q <= emit_res;
		for (int j = 0; j < NUM_SLOTS; j++) begin
			if (do_snap) snap_q[j] <= rank_q[j];
			if (do_step && hit[j] && period_e != '0)
				deadline_q[j] <= tick_q + period_e;
			if (do_cmd && cmd.op == OP_ADD && sel[j]) begin
				deadline_q[j] <= tick_q + w;
				period_q[j]   <= cmd.periodic ? w : '0;
			end
		end
	end

	assign res.valid   = out_valid_q;
	assign res.kind    = out_q.kind;
	assign res.slot_id = out_q.slot_id;
	assign res.status  = out_q.status;
	assign res.last    = out_q.last;

endmodule

// ===== sv/ptq_checker.sv =====
// Port checker for the timer event queue and its bind.
`include "assert_macros.svh"
module ptq_checker import ptq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_kind,
	input logic [1:0] res_status,
	input logic       res_last
);

	`ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`ASSERT_IMP(a_expiry_ok, clk, arst_n, res_valid && res_kind == KIND_EXPIRY, res_status == STS_OK)
	`ASSERT_IMP(a_status_last, clk, arst_n, res_valid && res_kind == KIND_STATUS, res_last)

endmodule

bind periodic_timer_event_queue_unit ptq_checker u_ptq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_kind   (res.kind),
	.res_status (res.status),
	.res_last   (res.last)
);
